// ----- sv/bcpa_pkg.sv -----
// Shared types and constants for the bitmap contiguous page allocator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bcpa_pkg;

	localparam int CNT_W     = 13;
	localparam int ADDR_W    = 32;
	localparam int CHUNK     = 8;   // pages per map word
	localparam int LOG_CHUNK = 3;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOSPACE = 2'd1,
		ST_INVALID = 2'd2
	} status_t;

	localparam logic [1:0] REG_BASE  = 2'd0;
	localparam logic [1:0] REG_PAGES = 2'd1;
	localparam logic [1:0] REG_RSV   = 2'd2;

	typedef struct packed {
		logic    capture;     // latch an incoming request
		logic    calc_off;    // address minus base
		logic    check_load;  // latch run bounds of a free request
		logic    walk_start;  // load word walker
		logic    walk_scan;   // walker covers the whole map
		logic    walk_rd;     // issue one map read
		logic    scan_eval;   // evaluate a word for a free run
		logic    walk_set;    // set run bits in the word read
		logic    walk_clr;    // clear run bits in the word read
		logic    fchk;        // check run bits are all used
		logic    clr;         // clearing pass, one word per cycle
		logic    res_load;
		logic    res_alloc;   // result carries the granted address
		status_t res_code;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		logic ev_vld;
		logic ev_last;
		logic scan_hit;
		logic scan_over;
		logic chk_bad;
		logic ptr_last;
		logic cnt_zero;
		logic req_bad;
		logic mode_free;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

// ----- sv/bitmap_contiguous_page_allocator.sv -----
// Top level of the bitmap first-fit page allocator.
// Instantiates bcpa_regs, bcpa_ctrl and bcpa_dp; depends on bcpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Bitmap first-fit page allocator. One used bit per page, held 8 pages to a
// word in a single-port-write / one-read map memory. An allocate request
// (mode 0) scans the map from page 0 one word per cycle for the lowest run of
// page_count free pages above the reserved pages and below pages_in_use,
// then marks that run used one word per cycle and returns
// base_address + start << PAGE_SHIFT. A free request (mode 1) checks
// alignment and range, walks the run once to confirm every page is used and
// once more to clear it. A zero count, or a free that fails the alignment or
// range check, is answered as invalid without a map walk. One request is
// worked at a time; the next is taken once the result sits in the output
// register, even if the consumer is still stalling it. After reset the map
// is cleared in a pass over every map word during which in_stall stays
// high; register writes are taken throughout. The user must write
// configuration only while the block is idle; the block itself does not
// enforce this.

module bitmap_contiguous_page_allocator #(
	parameter int MAP_PAGES  = 4096,
	parameter int PAGE_SHIFT = 12
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        mode,
	input  wire logic [31:0] free_address,
	input  wire logic [12:0] page_count,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [31:0] granted_address,
	output logic      [1:0]  status,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	import bcpa_pkg::*;

	cmd_t        cmd;
	stat_t       st;
	logic [31:0] base_address;
	logic [12:0] pages_in_use;
	logic [12:0] reserved_pages;

	bcpa_regs u_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.base_address   (base_address),
		.pages_in_use   (pages_in_use),
		.reserved_pages (reserved_pages)
	);

	bcpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.st       (st)
	);

	bcpa_dp #(
		.MAP_PAGES  (MAP_PAGES),
		.PAGE_SHIFT (PAGE_SHIFT)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.in_mode         (mode),
		.in_addr         (free_address),
		.in_cnt          (page_count),
		.base_address    (base_address),
		.pages_in_use    (pages_in_use),
		.reserved_pages  (reserved_pages),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.granted_address (granted_address),
		.status          (status)
	);

endmodule

`default_nettype wire

// ----- sv/bcpa_regs.sv -----
// Configuration register file with an APB-style access port.
// Depends on bcpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bcpa_regs (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output logic      [31:0] base_address,
	output logic      [12:0] pages_in_use,
	output logic      [12:0] reserved_pages
);
	import bcpa_pkg::*;

	logic [31:0] base_q;
	logic [12:0] pages_q;
	logic [12:0] rsv_q;
	logic [1:0]  idx;
	logic        wr;

	assign idx    = paddr[3:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= 32'h0020_0000;
			pages_q <= 13'd4096;
			rsv_q   <= 13'd2;
		end else if (wr) begin
			case (idx)
				REG_BASE:  base_q  <= pwdata;
				REG_PAGES: pages_q <= pwdata[12:0];
				REG_RSV:   rsv_q   <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_BASE:  prdata = base_q;
			REG_PAGES: prdata = {19'd0, pages_q};
			REG_RSV:   prdata = {19'd0, rsv_q};
			default:   prdata = 32'd0;
		endcase
	end

	assign base_address   = base_q;
	assign pages_in_use   = pages_q;
	assign reserved_pages = rsv_q;

endmodule

`default_nettype wire

// ----- sv/bcpa_dp.sv -----
// Datapath: request registers, used-page map memory, word walker, run
// search, range checks and result register. Depends on bcpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bcpa_dp #(
	parameter int MAP_PAGES  = 4096,
	parameter int PAGE_SHIFT = 12
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire bcpa_pkg::cmd_t        cmd,
	output bcpa_pkg::stat_t            st,
	input  wire logic                  in_mode,
	input  wire logic [31:0]           in_addr,
	input  wire logic [12:0]           in_cnt,
	input  wire logic [31:0]           base_address,
	input  wire logic [12:0]           pages_in_use,
	input  wire logic [12:0]           reserved_pages,
	input  wire logic                  out_stall,
	output logic                       out_valid,
	output logic [31:0]                granted_address,
	output logic [1:0]                 status
);
	import bcpa_pkg::*;

	localparam int NW   = (MAP_PAGES + CHUNK - 1) / CHUNK;
	localparam int WAW  = (NW > 1) ? $clog2(NW) : 1;
	localparam int PGW  = $clog2(MAP_PAGES);
	localparam int IW   = $clog2(MAP_PAGES + 1);
	localparam int KW0  = (IW > CNT_W) ? IW : CNT_W;
	localparam int KW   = (KW0 > WAW + LOG_CHUNK) ? KW0 : WAW + LOG_CHUNK;
	localparam int XW   = ADDR_W + 1;

	// request
	logic              mode_q;
	logic [31:0]       addr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [XW-1:0]     off_q;
	logic [PGW-1:0]    lo_q, hi_q;

	// map walker
	logic [CHUNK-1:0]  mem [NW];
	logic [WAW-1:0]    rd_ptr_q, wlast_q, ev_addr_s1;
	logic              ev_vld_s1;
	logic [CHUNK-1:0]  rdata_s1;
	logic [CNT_W-1:0]  run_q;
	logic              bad_q;

	// result
	status_t           res_code_q;
	logic [31:0]       res_addr_q;
	logic              out_valid_q;
	logic [31:0]       out_addr_q;
	logic [1:0]        out_code_q;

	logic [KW-1:0]     size_k, rsv_k;
	logic [XW-1:0]     idx_x, end_x;
	logic              req_bad;
	logic [WAW-1:0]    lo_word, hi_word;

	logic [CNT_W-1:0]  run_v;
	logic              hit_v, over_v, in_r, fr;
	logic [KW-1:0]     hend_v, pg;
	logic [CHUNK-1:0]  msk;
	logic [KW-1:0]     pgm;
	logic              cur_bad;

	logic              mem_we;
	logic [WAW-1:0]    mem_wa;
	logic [CHUNK-1:0]  mem_wd;

	// effective managed and reserved counts
	always_comb begin
		if (KW'(pages_in_use) > KW'(MAP_PAGES)) size_k = KW'(MAP_PAGES);
		else size_k = KW'(pages_in_use);
		if (KW'(reserved_pages) > size_k) rsv_k = size_k;
		else rsv_k = KW'(reserved_pages);
	end

	// free request range check
	assign idx_x   = XW'(off_q[31:PAGE_SHIFT]);
	assign end_x   = idx_x + XW'(cnt_q);
	assign req_bad = off_q[XW-1] || (|off_q[PAGE_SHIFT-1:0]) ||
		(end_x > XW'(size_k)) || (idx_x < XW'(rsv_k));

	assign lo_word = WAW'(lo_q >> LOG_CHUNK);
	assign hi_word = WAW'(hi_q >> LOG_CHUNK);

	// first-fit search over one word, run length carried in
	always_comb begin
		run_v  = run_q;
		hit_v  = 1'b0;
		over_v = (ev_addr_s1 == wlast_q);
		hend_v = '0;
		pg     = '0;
		in_r   = 1'b0;
		fr     = 1'b0;
		for (int b = 0; b < CHUNK; b++) begin
			pg   = KW'({ev_addr_s1, LOG_CHUNK'(b)});
			in_r = pg < size_k;
			fr   = in_r && (pg >= rsv_k) && !rdata_s1[b];
			if (!in_r) begin
				over_v = 1'b1;
			end else if (!hit_v) begin
				run_v = fr ? CNT_W'(run_v + 1'b1) : '0;
				if (fr && run_v == cnt_q) begin
					hit_v  = 1'b1;
					hend_v = pg;
				end
			end
		end
	end

	// run mask for the word under evaluation
	always_comb begin
		msk = '0;
		pgm = '0;
		for (int b = 0; b < CHUNK; b++) begin
			pgm    = KW'({ev_addr_s1, LOG_CHUNK'(b)});
			msk[b] = (pgm >= KW'(lo_q)) && (pgm <= KW'(hi_q));
		end
	end
	assign cur_bad = |(msk & ~rdata_s1);

	always_comb begin
		mem_we = cmd.clr || (ev_vld_s1 && (cmd.walk_set || cmd.walk_clr));
		mem_wa = cmd.clr ? rd_ptr_q : ev_addr_s1;
		if (cmd.clr) mem_wd = '0;
		else if (cmd.walk_set) mem_wd = rdata_s1 | msk;
		else mem_wd = rdata_s1 & ~msk;
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rdata_s1 <= mem[rd_ptr_q];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= in_mode;
			addr_q <= in_addr;
			cnt_q  <= in_cnt;
		end
		if (cmd.calc_off) off_q <= {1'b0, addr_q} - {1'b0, base_address};
		if (cmd.check_load) begin
			lo_q <= PGW'(idx_x);
			hi_q <= PGW'(end_x - 1'b1);
		end else if (cmd.scan_eval && ev_vld_s1 && hit_v) begin
			lo_q <= PGW'(hend_v + 1'b1 - KW'(cnt_q));
			hi_q <= PGW'(hend_v);
		end
		ev_addr_s1 <= rd_ptr_q;
		if (cmd.walk_start) begin
			run_q <= '0;
		end else if (cmd.scan_eval && ev_vld_s1) begin
			run_q <= run_v;
		end
		if (cmd.res_load) begin
			res_code_q <= cmd.res_code;
			res_addr_q <= cmd.res_alloc ?
				32'(base_address + (32'(lo_q) << PAGE_SHIFT)) : 32'd0;
		end
		if (cmd.out_load) begin
			out_addr_q <= res_addr_q;
			out_code_q <= res_code_q;
		end
	end

	// walker control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q  <= '0;
			wlast_q   <= '0;
			ev_vld_s1 <= 1'b0;
			bad_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			ev_vld_s1 <= cmd.walk_rd;
			if (cmd.walk_start) begin
				rd_ptr_q <= cmd.walk_scan ? '0 : lo_word;
				wlast_q  <= cmd.walk_scan ? WAW'(NW - 1) : hi_word;
				bad_q    <= 1'b0;
			end else begin
				if (cmd.clr && rd_ptr_q != WAW'(NW - 1))
					rd_ptr_q <= WAW'(rd_ptr_q + 1'b1);
				else if (cmd.walk_rd && rd_ptr_q != wlast_q)
					rd_ptr_q <= WAW'(rd_ptr_q + 1'b1);
				if (cmd.fchk && ev_vld_s1) bad_q <= bad_q | cur_bad;
			end
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		st.ev_vld    = ev_vld_s1;
		st.ev_last   = ev_addr_s1 == wlast_q;
		st.scan_hit  = hit_v;
		st.scan_over = over_v;
		st.chk_bad   = bad_q | cur_bad;
		st.ptr_last  = rd_ptr_q == WAW'(NW - 1);
		st.cnt_zero  = cnt_q == '0;
		st.req_bad   = req_bad;
		st.mode_free = mode_q;
		st.out_free  = !out_valid_q || !out_stall;
	end

	assign out_valid       = out_valid_q;
	assign granted_address = out_addr_q;
	assign status          = out_code_q;

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("result not presented after load");
	a_walk_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.walk_rd && !cmd.walk_start) |-> rd_ptr_q <= wlast_q)
		else $error("walker ran past its last word");
	a_no_double_wr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr |-> !(cmd.walk_set || cmd.walk_clr))
		else $error("clearing pass overlaps a map update");

endmodule

`default_nettype wire

// ----- sv/bcpa_ctrl.sv -----
// Controller state machine: sequences checks, map scan, marking and
// freeing, and the clearing pass. Depends on bcpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bcpa_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	output bcpa_pkg::cmd_t       cmd,
	input  wire bcpa_pkg::stat_t st
);
	import bcpa_pkg::*;

	typedef enum logic [11:0] {
		S_CLEAR = 12'b0000_0000_0001,
		S_IDLE  = 12'b0000_0000_0010,
		S_OFFS  = 12'b0000_0000_0100,
		S_CHECK = 12'b0000_0000_1000,
		S_SCAN  = 12'b0000_0001_0000,
		S_APREP = 12'b0000_0010_0000,
		S_AMARK = 12'b0000_0100_0000,
		S_FPREP = 12'b0000_1000_0000,
		S_FCHK  = 12'b0001_0000_0000,
		S_CPREP = 12'b0010_0000_0000,
		S_FCLR  = 12'b0100_0000_0000,
		S_RESP  = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= state_n;
	end

	assign in_stall = state_q != S_IDLE;

	always_comb begin
		cmd      = '0;
		cmd.res_code = ST_OK;
		state_n  = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (st.ptr_last) state_n = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_n = S_OFFS;
				end
			end
			S_OFFS: begin
				cmd.calc_off = 1'b1;
				state_n = S_CHECK;
			end
			S_CHECK: begin
				if (st.cnt_zero || (st.mode_free && st.req_bad)) begin
					cmd.res_load = 1'b1;
					cmd.res_code = ST_INVALID;
					state_n = S_RESP;
				end else if (!st.mode_free) begin
					cmd.walk_start = 1'b1;
					cmd.walk_scan  = 1'b1;
					state_n = S_SCAN;
				end else begin
					cmd.check_load = 1'b1;
					state_n = S_FPREP;
				end
			end
			S_SCAN: begin
				cmd.walk_rd   = 1'b1;
				cmd.scan_eval = 1'b1;
				if (st.ev_vld) begin
					if (st.scan_hit) begin
						state_n = S_APREP;
					end else if (st.scan_over) begin
						cmd.res_load = 1'b1;
						cmd.res_code = ST_NOSPACE;
						state_n = S_RESP;
					end
				end
			end
			S_APREP: begin
				cmd.walk_start = 1'b1;
				state_n = S_AMARK;
			end
			S_AMARK: begin
				cmd.walk_rd  = 1'b1;
				cmd.walk_set = 1'b1;
				if (st.ev_vld && st.ev_last) begin
					cmd.res_load  = 1'b1;
					cmd.res_alloc = 1'b1;
					state_n = S_RESP;
				end
			end
			S_FPREP: begin
				cmd.walk_start = 1'b1;
				state_n = S_FCHK;
			end
			S_FCHK: begin
				cmd.walk_rd = 1'b1;
				cmd.fchk    = 1'b1;
				if (st.ev_vld && st.ev_last) begin
					if (st.chk_bad) begin
						cmd.res_load = 1'b1;
						cmd.res_code = ST_INVALID;
						state_n = S_RESP;
					end else begin
						state_n = S_CPREP;
					end
				end
			end
			S_CPREP: begin
				cmd.walk_start = 1'b1;
				state_n = S_FCLR;
			end
			S_FCLR: begin
				cmd.walk_rd  = 1'b1;
				cmd.walk_clr = 1'b1;
				if (st.ev_vld && st.ev_last) begin
					cmd.res_load = 1'b1;
					state_n = S_RESP;
				end
			end
			S_RESP: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	a_resp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && !st.out_free) |=> state_q == S_RESP)
		else $error("result dropped while output busy");
	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> in_stall)
		else $error("request taken during clearing pass");
	a_mark_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_AMARK && $past(state_q) != S_AMARK) |-> $past(state_q) == S_APREP)
		else $error("marking started without a found run");

endmodule

`default_nettype wire

// ----- dv/tb_bitmap_contiguous_page_allocator.sv -----
// Self-checking testbench for the bitmap contiguous page allocator.
// Drives allocate/free requests with a scoreboard predictor; depends on bcpa_pkg and the RTL.
`timescale 1ns / 1ps

module tb_bitmap_contiguous_page_allocator;
	import bcpa_pkg::*;

	localparam int NPAGES = 4096;
	localparam int PSHIFT = 12;
	localparam int N_RAND = 1930;
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef struct {
		logic        md;
		logic [31:0] addr;
		logic [12:0] cnt;
		bit          has_exp;   // typed-in expectation present
		logic [31:0] exp_addr;
		status_t     exp_st;
	} req_row_t;

	typedef struct {
		logic [31:0] addr;
		status_t     st;
	} grant_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        mode = 1'b0;
	logic [31:0] free_address = '0;
	logic [12:0] page_count = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] granted_address;
	logic [1:0]  status;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	always #5 clk = ~clk;

	bitmap_contiguous_page_allocator u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .mode(mode),
		.free_address(free_address), .page_count(page_count),
		.out_valid(out_valid), .out_stall(out_stall),
		.granted_address(granted_address), .status(status),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	bit          page_used[NPAGES];
	logic [31:0] cfg_base;
	logic [12:0] cfg_pages;
	logic [12:0] cfg_rsv;

	grant_t grants_due[$];
	int     n_err = 0;
	int     n_seen = 0;
	int     n_alloc_ok = 0, n_free_ok = 0, n_nospace = 0, n_invalid = 0;
	bit     long_hold = 1'b0;   // receiver holds off for a long stretch
	req_row_t dir_rows[$];

	// Expected result of one request; updates the page map.
	function automatic grant_t alloc_or_free(logic md, logic [31:0] addr, logic [12:0] cnt);
		grant_t r;
		longint size, rsv, run, start, off, idx;
		r.addr = '0;
		r.st = ST_INVALID;
		size = (cfg_pages > NPAGES) ? NPAGES : cfg_pages;
		rsv = (cfg_rsv > size) ? size : cfg_rsv;
		if (cnt == 0)
			return r;
		if (md == MODE_ALLOC) begin
			run = 0;
			r.st = ST_NOSPACE;
			for (longint i = 0; i < size; i++) begin
				if (i < rsv || page_used[i]) begin
					run = 0;
				end else begin
					run++;
					if (run == cnt) begin
						start = i + 1 - cnt;
						for (longint j = start; j <= i; j++)
							page_used[j] = 1'b1;
						r.addr = cfg_base + 32'(start << PSHIFT);
						r.st = ST_OK;
						return r;
					end
				end
			end
			return r;
		end
		if (addr < cfg_base)
			return r;
		off = addr - cfg_base;
		if (off[PSHIFT-1:0] != 0)
			return r;
		idx = off >> PSHIFT;
		if (idx > size || cnt > size - idx || idx < rsv)
			return r;
		for (longint i = idx; i < idx + cnt; i++)
			if (!page_used[i])
				return r;
		for (longint i = idx; i < idx + cnt; i++)
			page_used[i] = 1'b0;
		r.st = ST_OK;
		return r;
	endfunction

	task automatic idle_cycles(int n);
		repeat (n) @(posedge clk);
	endtask

	// APB write: setup then access; pready is always high
	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 4'(idx) << 2;
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_BASE:  cfg_base  = val;
			REG_PAGES: cfg_pages = val[12:0];
			REG_RSV:   cfg_rsv   = val[12:0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (grants_due.size() != 0) @(posedge clk);
		idle_cycles(600);   // allow the longest scan to settle
	endtask

	// Send one request; the optional typed expectation overrides the predictor.
	// in_valid stays high into the next request when it follows with no gap.
	task automatic send_request(req_row_t row, int gap);
		grant_t g;
		if (gap > 0) begin
			in_valid <= 1'b0;
			idle_cycles(gap);
		end
		mode         <= row.md;
		free_address <= row.addr;
		page_count   <= row.cnt;
		in_valid     <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		g = alloc_or_free(row.md, row.addr, row.cnt);
		if (row.has_exp && (g.addr != row.exp_addr || g.st != row.exp_st)) begin
			$display("ERROR: predictor disagrees with table row: %h/%0d vs %h/%0d",
				g.addr, g.st, row.exp_addr, row.exp_st);
			n_err++;
		end
		if (row.has_exp) begin
			g.addr = row.exp_addr;
			g.st = row.exp_st;
		end
		grants_due.push_back(g);
	endtask

	function automatic req_row_t mk(logic md, logic [31:0] a, logic [12:0] c,
			bit he = 0, logic [31:0] ea = '0, status_t es = ST_OK);
		req_row_t r;
		r.md = md; r.addr = a; r.cnt = c;
		r.has_exp = he; r.exp_addr = ea; r.exp_st = es;
		return r;
	endfunction

	// Receiver: random stalls, one long hold-off, checks each result.
	initial begin : result_monitor
		grant_t e;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				n_seen++;
				if (grants_due.size() == 0) begin
					n_err++;
					if (n_err <= 10)
						$display("ERROR: unexpected result %h/%0d", granted_address, status);
				end else begin
					e = grants_due.pop_front();
					if (granted_address !== e.addr || status !== e.st) begin
						n_err++;
						if (n_err <= 10)
							$display("ERROR: result got %h/%0d want %h/%0d",
								granted_address, status, e.addr, e.st);
					end
					case (e.st)
						ST_OK:      ;
						ST_NOSPACE: n_nospace++;
						default:    n_invalid++;
					endcase
				end
			end
		end
	end

	initial begin : stall_driver
		int w;
		forever begin
			if (long_hold) begin
				out_stall <= 1'b1;
				idle_cycles(3000);
				long_hold = 1'b0;
			end
			w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
			out_stall <= (w != 0);
			idle_cycles(w == 0 ? $urandom_range(1, 40) : w);
			out_stall <= 1'b0;
			@(posedge clk);
		end
	end

	initial begin : watchdog
		#200ms;
		$display("tb: failure");
		$finish;
	end

	// Random request: mostly sane allocate/free pairs from the live map.
	function automatic req_row_t random_request(logic [31:0] live_addr[$]);
		req_row_t r;
		int k;
		r = mk(1'($urandom_range(0, 1)), $urandom, 13'($urandom_range(1, 8)));
		k = $urandom_range(0, 19);
		if (k == 0) r.cnt = 13'($urandom);
		else if (k == 1) r.cnt = 0;
		else if (k < 4) r.cnt = 13'($urandom_range(1, 300));
		if (r.md == MODE_FREE && live_addr.size() != 0 && $urandom_range(0, 4) != 0) begin
			r.addr = live_addr[$urandom_range(0, live_addr.size() - 1)];
			if ($urandom_range(0, 9) == 0) r.addr += 32'($urandom_range(1, 4095));
		end
		return r;
	endfunction

	initial begin : stimulus
		logic [31:0] live[$];
		req_row_t r;
		grant_t snap;
		logic [31:0] bases[4] = '{32'h0020_0000, 32'h0, 32'hFFFF_0000, 32'h1234_5000};
		logic [12:0] sizes[4] = '{13'd4096, 13'd1, 13'd8191, 13'd64};
		logic [12:0] rsvs[4]  = '{13'd2, 13'd0, 13'd8191, 13'd5};
		cfg_base = 32'h0020_0000;
		cfg_pages = 13'd4096;
		cfg_rsv = 13'd2;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table at reset configuration: base 0x200000, rsv 2.
		dir_rows.push_back(mk(MODE_ALLOC, '0, 13'd0, 1, 32'h0, ST_INVALID));
		dir_rows.push_back(mk(MODE_FREE, 32'h0020_2000, 13'd0, 1, 32'h0, ST_INVALID));
		dir_rows.push_back(mk(MODE_ALLOC, '0, 13'd1, 1, 32'h0020_2000, ST_OK));
		dir_rows.push_back(mk(MODE_ALLOC, 32'hFFFF_FFFF, 13'd3, 1, 32'h0020_3000, ST_OK));
		dir_rows.push_back(mk(MODE_ALLOC, '0, 13'd8191, 1, 32'h0, ST_NOSPACE));
		dir_rows.push_back(mk(MODE_ALLOC, '0, 13'd4097, 1, 32'h0, ST_NOSPACE));
		dir_rows.push_back(mk(MODE_FREE, 32'h001F_F000, 13'd1, 1, 32'h0, ST_INVALID));
		dir_rows.push_back(mk(MODE_FREE, 32'h0020_2800, 13'd1, 1, 32'h0, ST_INVALID));
		dir_rows.push_back(mk(MODE_FREE, 32'h0020_0000, 13'd1, 1, 32'h0, ST_INVALID));
		dir_rows.push_back(mk(MODE_FREE, 32'h0120_0000, 13'd1, 1, 32'h0, ST_INVALID));
		dir_rows.push_back(mk(MODE_FREE, 32'h0020_2000, 13'd5, 1, 32'h0, ST_INVALID));
		dir_rows.push_back(mk(MODE_FREE, 32'h0020_3000, 13'd3, 1, 32'h0, ST_OK));
		dir_rows.push_back(mk(MODE_FREE, 32'h0020_3000, 13'd1, 1, 32'h0, ST_INVALID));
		dir_rows.push_back(mk(MODE_FREE, 32'hFFFF_FFFF, 13'h1FFF, 1, 32'h0, ST_INVALID));
		dir_rows.push_back(mk(MODE_ALLOC, '0, 13'd2, 1, 32'h0020_3000, ST_OK));
		dir_rows.push_back(mk(MODE_ALLOC, '0, 13'd4094 - 13'd3, 0));
		dir_rows.push_back(mk(MODE_ALLOC, '0, 13'd1, 1, 32'h0, ST_NOSPACE));
		dir_rows.push_back(mk(MODE_FREE, 32'h0020_2000, 13'd4094, 1, 32'h0, ST_OK));
		dir_rows.push_back(mk(MODE_ALLOC, '0, 13'd4094, 1, 32'h0020_2000, ST_OK));
		dir_rows.push_back(mk(MODE_FREE, 32'h0020_2000, 13'd4094, 1, 32'h0, ST_OK));
		foreach (dir_rows[i])
			send_request(dir_rows[i], $urandom_range(0, 18));
		wait_drained();

		// Random phases over several register settings, extremes included.
		for (int ph = 0; ph < 8; ph++) begin
			live.delete();
			reg_write(REG_BASE, ph < 4 ? bases[ph] : $urandom);
			reg_write(REG_PAGES, ph < 4 ? 32'(sizes[ph]) : $urandom_range(1, 4096));
			reg_write(REG_RSV, ph < 4 ? 32'(rsvs[ph]) : $urandom_range(0, 40));
			if (ph == 2) long_hold = 1'b1;
			for (int n = 0; n < N_RAND / 8; n++) begin
				r = random_request(live);
				if (ph == 5 && n == 100) begin
					// sender pauses until everything is back
					in_valid <= 1'b0;
					while (grants_due.size() != 0) @(posedge clk);
				end
				send_request(r, $urandom_range(0, 4) == 0 ? 0 : $urandom_range(0, 18));
				snap = grants_due[$];
				if (r.md == MODE_ALLOC && snap.st == ST_OK) begin
					live.push_back(snap.addr);
					n_alloc_ok++;
				end else if (r.md == MODE_FREE && snap.st == ST_OK) begin
					n_free_ok++;
				end
				if (live.size() > 60) live.delete(0);
			end
			wait_drained();
		end

		$display("run: %0d results checked; %0d allocs, %0d frees ok, %0d no-space, %0d invalid",
			n_seen, n_alloc_ok, n_free_ok, n_nospace, n_invalid);
		$display("run: eight register settings including zero and wrapping base, size 1 and max");
		if (n_err == 0 && grants_due.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ----- files.f -----
sv/bcpa_pkg.sv
sv/bcpa_regs.sv
sv/bcpa_dp.sv
sv/bcpa_ctrl.sv
sv/bitmap_contiguous_page_allocator.sv
dv/tb_bitmap_contiguous_page_allocator.sv
